// ===== design/simplified_aes_block_cipher_macros.svh =====
// Assertion macros shared by the checker of the S-AES block.
`ifndef SIMPLIFIED_AES_BLOCK_CIPHER_MACROS_SVH
`define SIMPLIFIED_AES_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SAES_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SAES_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/saes_pkg.sv =====
// Types, constants and round functions of the S-AES block.
package saes_pkg;

	localparam int BLK_W = 16;
	localparam int NIB_W = 4;
	localparam int BYTE_W = 8;

	localparam logic [BYTE_W-1:0] RCON_1 = 8'b1000_0000;
	localparam logic [BYTE_W-1:0] RCON_2 = 8'b0011_0000;
	// x^4 + x + 1, the x^4 term dropped
	localparam logic [NIB_W-1:0] GF_POLY_LO = 4'b0011;

	localparam logic [NIB_W-1:0] MIX_FWD_P = 4'h1;
	localparam logic [NIB_W-1:0] MIX_FWD_Q = 4'h4;
	localparam logic [NIB_W-1:0] MIX_INV_P = 4'h9;
	localparam logic [NIB_W-1:0] MIX_INV_Q = 4'h2;

	localparam logic KIND_DECRYPT = 1'b0;
	localparam logic KIND_ENCRYPT = 1'b1;

	typedef logic [BLK_W-1:0] blk_t;
	typedef logic [NIB_W-1:0] nib_t;
	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		blk_t k0;
		blk_t k1;
		blk_t k2;
	} saes_rkeys_t;

	function automatic nib_t sbox_fwd(input nib_t n);
		nib_t r;
		case (n)
			4'h0: r = 4'h9;
			4'h1: r = 4'h4;
			4'h2: r = 4'hA;
			4'h3: r = 4'hB;
			4'h4: r = 4'hD;
			4'h5: r = 4'h1;
			4'h6: r = 4'h8;
			4'h7: r = 4'h5;
			4'h8: r = 4'h6;
			4'h9: r = 4'h2;
			4'hA: r = 4'h0;
			4'hB: r = 4'h3;
			4'hC: r = 4'hC;
			4'hD: r = 4'hE;
			4'hE: r = 4'hF;
			default: r = 4'h7;
		endcase
		return r;
	endfunction

	function automatic nib_t sbox_inv(input nib_t n);
		nib_t r;
		case (n)
			4'h0: r = 4'hA;
			4'h1: r = 4'h5;
			4'h2: r = 4'h9;
			4'h3: r = 4'hB;
			4'h4: r = 4'h1;
			4'h5: r = 4'h7;
			4'h6: r = 4'h8;
			4'h7: r = 4'hF;
			4'h8: r = 4'h6;
			4'h9: r = 4'h0;
			4'hA: r = 4'h2;
			4'hB: r = 4'h3;
			4'hC: r = 4'hC;
			4'hD: r = 4'h4;
			4'hE: r = 4'hD;
			default: r = 4'hE;
		endcase
		return r;
	endfunction

	function automatic nib_t gf_mul(input nib_t a, input nib_t b);
		nib_t acc;
		nib_t x;
		acc = '0;
		x = a;
		for (int i = 0; i < NIB_W; i++) begin
			if (b[i])
				acc = acc ^ x;
			x = {x[NIB_W-2:0], 1'b0} ^ (x[NIB_W-1] ? GF_POLY_LO : '0);
		end
		return acc;
	endfunction

	function automatic blk_t sub_fwd(input blk_t v);
		return {sbox_fwd(v[15:12]), sbox_fwd(v[11:8]), sbox_fwd(v[7:4]), sbox_fwd(v[3:0])};
	endfunction

	function automatic blk_t sub_inv(input blk_t v);
		return {sbox_inv(v[15:12]), sbox_inv(v[11:8]), sbox_inv(v[7:4]), sbox_inv(v[3:0])};
	endfunction

	// swap n1 and n3
	function automatic blk_t shift_row(input blk_t v);
		return {v[15:12], v[3:0], v[7:4], v[11:8]};
	endfunction

	// each column (top, bottom) times {p,q;q,p}
	function automatic blk_t mix(input blk_t v, input nib_t p, input nib_t q);
		nib_t m0;
		nib_t m1;
		nib_t m2;
		nib_t m3;
		m0 = gf_mul(p, v[15:12]) ^ gf_mul(q, v[11:8]);
		m1 = gf_mul(q, v[15:12]) ^ gf_mul(p, v[11:8]);
		m2 = gf_mul(p, v[7:4]) ^ gf_mul(q, v[3:0]);
		m3 = gf_mul(q, v[7:4]) ^ gf_mul(p, v[3:0]);
		return {m0, m1, m2, m3};
	endfunction

	// RotNib then SubNib on one byte
	function automatic byte_t rot_sub(input byte_t b);
		return {sbox_fwd(b[3:0]), sbox_fwd(b[7:4])};
	endfunction

	function automatic saes_rkeys_t expand(input blk_t key);
		byte_t w0;
		byte_t w1;
		byte_t w2;
		byte_t w3;
		byte_t w4;
		byte_t w5;
		saes_rkeys_t rk;
		w0 = key[15:8];
		w1 = key[7:0];
		w2 = w0 ^ RCON_1 ^ rot_sub(w1);
		w3 = w2 ^ w1;
		w4 = w2 ^ RCON_2 ^ rot_sub(w3);
		w5 = w4 ^ w3;
		rk.k0 = {w0, w1};
		rk.k1 = {w2, w3};
		rk.k2 = {w4, w5};
		return rk;
	endfunction

	localparam saes_rkeys_t RKEYS_RST = expand('0);

endpackage

// ===== design/saes_if.sv =====
// Valid/ready channel interfaces for S-AES input and result words.
interface saes_in_if import saes_pkg::*; ();
	logic valid;
	logic ready;
	logic kind;
	blk_t data_block;

	modport source(output valid, output kind, output data_block, input ready);
	modport sink(input valid, input kind, input data_block, output ready);
endinterface

interface saes_out_if import saes_pkg::*; ();
	logic valid;
	logic ready;
	blk_t result_block;

	modport source(output valid, output result_block, input ready);
	modport sink(input valid, input result_block, output ready);
endinterface

// ===== design/simplified_aes_block_cipher.sv =====
// Top level of the S-AES block cipher: key port, input stage, rounds, result stage.
// S-AES (16-bit block, 16-bit key). Writing cfg_wdata with cfg_we high loads the key
// and its three expanded round keys into a register; a word may follow in the next cycle.
// Each input word (kind 1 encrypts, 0 decrypts) is taken into an input register, passes
// both rounds in combinational logic and lands in the result register: one word per
// cycle sustained while dout is not stalled. din.ready drops only when both stages are full
// and dout is stalled. Reset leaves the all-zero key in place.
module simplified_aes_block_cipher import saes_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input blk_t cfg_wdata,
	saes_in_if.sink din,
	saes_out_if.source dout
);

	saes_rkeys_t rkeys;
	logic vld_s1;
	logic kind_s1;
	blk_t blk_s1;
	logic vld_s2;
	blk_t res_s2;
	blk_t res_comb;
	logic adv_s2;
	logic take_s1;

	saes_key_sched u_key_sched (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.rkeys(rkeys)
	);

	saes_rounds u_rounds (
		.kind(kind_s1),
		.data_block(blk_s1),
		.rkeys(rkeys),
		.result_block(res_comb)
	);

	assign adv_s2 = !vld_s2 || dout.ready;
	assign din.ready = !vld_s1 || adv_s2;
	assign take_s1 = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (din.ready) begin
			vld_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			kind_s1 <= din.kind;
			blk_s1 <= din.data_block;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign dout.valid = vld_s2;
	assign dout.result_block = res_s2;

endmodule

// ===== design/saes_key_sched.sv =====
// Key register and round-key expansion, loaded on each key write.
module saes_key_sched import saes_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input blk_t cfg_wdata,
	output saes_rkeys_t rkeys
);

	saes_rkeys_t rkeys_q;

	// expanded from write data so the keys are ready the cycle after the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rkeys_q <= RKEYS_RST;
		end else if (cfg_we) begin
			rkeys_q <= expand(cfg_wdata);
		end
	end

	assign rkeys = rkeys_q;

endmodule

// ===== design/saes_rounds.sv =====
// Full encrypt or decrypt path of one block between the pipeline registers.
module saes_rounds import saes_pkg::*; (
	input logic kind,
	input blk_t data_block,
	input saes_rkeys_t rkeys,
	output blk_t result_block
);

	blk_t enc_a;
	blk_t enc_b;
	blk_t enc_r;
	blk_t dec_a;
	blk_t dec_b;
	blk_t dec_r;

	always_comb begin
		enc_a = data_block ^ rkeys.k0;
		enc_b = mix(shift_row(sub_fwd(enc_a)), MIX_FWD_P, MIX_FWD_Q) ^ rkeys.k1;
		enc_r = shift_row(sub_fwd(enc_b)) ^ rkeys.k2;
	end

	always_comb begin
		dec_a = data_block ^ rkeys.k2;
		dec_b = mix(sub_inv(shift_row(dec_a)) ^ rkeys.k1, MIX_INV_P, MIX_INV_Q);
		dec_r = sub_inv(shift_row(dec_b)) ^ rkeys.k0;
	end

	assign result_block = (kind == KIND_ENCRYPT) ? enc_r : dec_r;

endmodule

// ===== design/saes_chk.sv =====
// Port-level checker for the S-AES block, bound to the top level.
`include "simplified_aes_block_cipher_macros.svh"

module saes_chk import saes_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input blk_t out_result
);

	`SAES_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result word dropped while stalled")
	`SAES_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_result), "result word changed while stalled")
	`SAES_ASSERT_NOW(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready, "input stalled with result side free")
	`SAES_ASSERT_NOW(a_rise_src, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result word without input word two cycles before")

endmodule

bind simplified_aes_block_cipher saes_chk u_saes_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(din.valid),
	.in_ready(din.ready),
	.out_valid(dout.valid),
	.out_ready(dout.ready),
	.out_result(dout.result_block)
);

// ===== sim/saes_result_checker.sv =====
// Checker for the S-AES block: follows the key port, predicts every word and compares results.
`timescale 1ns / 100ps

module saes_result_checker import saes_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input blk_t cfg_wdata,
	saes_in_if din,
	saes_out_if dout,
	output int unsigned mismatches,
	output int unsigned blocks_in_flight,
	output int unsigned blocks_checked
);

	localparam nib_t ENC_BOX [16] = '{
		4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
		4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
	};
	localparam nib_t DEC_BOX [16] = '{
		4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
		4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
	};

	blk_t key_copy;
	blk_t expected_blocks [$];

	function automatic nib_t gf16_mul(input nib_t a, input nib_t b);
		nib_t prod;
		nib_t x;
		prod = '0;
		x = a;
		for (int i = 0; i < NIB_W; i++) begin
			if (b[i])
				prod = prod ^ x;
			x = x[NIB_W-1] ? (nib_t'(x << 1) ^ GF_POLY_LO) : nib_t'(x << 1);
		end
		return prod;
	endfunction

	function automatic blk_t sub_nibbles(input blk_t v, input logic inverse);
		blk_t r;
		for (int i = 0; i < 4; i++)
			r[4*i +: 4] = inverse ? DEC_BOX[v[4*i +: 4]] : ENC_BOX[v[4*i +: 4]];
		return r;
	endfunction

	// bottom row of the 2x2 nibble matrix swaps columns
	function automatic blk_t swap_row(input blk_t v);
		blk_t r;
		r = v;
		r[11:8] = v[3:0];
		r[3:0] = v[11:8];
		return r;
	endfunction

	function automatic blk_t mix_cols(input blk_t v, input nib_t p, input nib_t q);
		blk_t r;
		nib_t top_n;
		nib_t bot_n;
		for (int c = 0; c < 2; c++) begin
			top_n = v[15 - 8*c -: 4];
			bot_n = v[11 - 8*c -: 4];
			r[15 - 8*c -: 4] = gf16_mul(p, top_n) ^ gf16_mul(q, bot_n);
			r[11 - 8*c -: 4] = gf16_mul(q, top_n) ^ gf16_mul(p, bot_n);
		end
		return r;
	endfunction

	function automatic byte_t rot_sub_byte(input byte_t b);
		return {ENC_BOX[b[3:0]], ENC_BOX[b[7:4]]};
	endfunction

	function automatic void schedule(input blk_t key, output blk_t k0, output blk_t k1,
			output blk_t k2);
		byte_t w [6];
		w[0] = key[15:8];
		w[1] = key[7:0];
		w[2] = w[0] ^ RCON_1 ^ rot_sub_byte(w[1]);
		w[3] = w[2] ^ w[1];
		w[4] = w[2] ^ RCON_2 ^ rot_sub_byte(w[3]);
		w[5] = w[4] ^ w[3];
		k0 = {w[0], w[1]};
		k1 = {w[2], w[3]};
		k2 = {w[4], w[5]};
	endfunction

	function automatic blk_t saes_predict(input logic kind, input blk_t blk, input blk_t key);
		blk_t k0;
		blk_t k1;
		blk_t k2;
		blk_t s;
		schedule(key, k0, k1, k2);
		if (kind == KIND_ENCRYPT) begin
			s = blk ^ k0;
			s = mix_cols(swap_row(sub_nibbles(s, 1'b0)), MIX_FWD_P, MIX_FWD_Q) ^ k1;
			s = swap_row(sub_nibbles(s, 1'b0)) ^ k2;
		end else begin
			s = blk ^ k2;
			s = sub_nibbles(swap_row(s), 1'b1) ^ k1;
			s = mix_cols(s, MIX_INV_P, MIX_INV_Q);
			s = sub_nibbles(swap_row(s), 1'b1) ^ k0;
		end
		return s;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t saes_result_checker: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		blk_t want;
		if (!arst_n) begin
			key_copy <= '0;
			expected_blocks.delete();
			blocks_in_flight <= 0;
			blocks_checked <= 0;
			mismatches = 0;
		end else begin
			if (cfg_we)
				key_copy <= cfg_wdata;
			if (din.valid && din.ready)
				expected_blocks.push_back(saes_predict(din.kind, din.data_block, key_copy));
			if (dout.valid && dout.ready) begin
				if (expected_blocks.size() == 0) begin
					report_mismatch($sformatf("result %h with no word outstanding",
						dout.result_block));
				end else begin
					want = expected_blocks.pop_front();
					blocks_checked <= blocks_checked + 1;
					if (dout.result_block !== want)
						report_mismatch($sformatf("word %0d: result %h, expected %h",
							blocks_checked, dout.result_block, want));
				end
			end
			blocks_in_flight <= expected_blocks.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// Top of the S-AES testbench: clock, reset, key loads, word stimulus and the verdict.
`timescale 1ns / 100ps

module tb_top import saes_pkg::*; ();

	localparam int QUIET_LIMIT = 2000;
	localparam int RAND_PHASES = 10;
	localparam int PHASE_WORDS = 110;
	localparam blk_t DIR_KEYS [3] = '{16'h4AF5, 16'h0000, 16'hFFFF};
	localparam blk_t DIR_BLOCKS [4] = '{16'h0000, 16'hFFFF, 16'hD728, 16'h24EC};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	blk_t cfg_wdata;
	bit calm;
	int unsigned idle_pct;
	int unsigned mismatches;
	int unsigned in_flight;
	int unsigned checked;
	int unsigned words_sent;
	int unsigned keys_loaded;
	int unsigned quiet;

	saes_in_if din();
	saes_out_if dout();

	simplified_aes_block_cipher dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.din(din),
		.dout(dout)
	);

	saes_result_checker result_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.din(din),
		.dout(dout),
		.mismatches(mismatches),
		.blocks_in_flight(in_flight),
		.blocks_checked(checked)
	);

	always #5 clk = ~clk;

	task automatic send_word(input logic kind, input blk_t blk);
		if (!calm && $urandom_range(99) < idle_pct) begin
			din.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		din.valid <= 1'b1;
		din.kind <= kind;
		din.data_block <= blk;
		@(posedge clk);
		while (!din.ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic drain();
		din.valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_key(input blk_t key);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= key;
		@(posedge clk);
		cfg_we <= 1'b0;
		keys_loaded++;
	endtask

	// result side back-pressure
	initial begin
		dout.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && !calm && $urandom_range(99) < idle_pct) begin
				dout.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			dout.ready <= 1'b1;
		end
	end

	initial begin
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_we || (din.valid && din.ready) || (dout.valid && dout.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top: no handshake for %0d cycles", QUIET_LIMIT);
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		blk_t key;
		blk_t blk;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		din.valid = 1'b0;
		din.kind = KIND_DECRYPT;
		din.data_block = '0;
		calm = 1'b0;
		idle_pct = 20;
		words_sent = 0;
		keys_loaded = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key
		send_word(KIND_ENCRYPT, 16'hD728);
		send_word(KIND_DECRYPT, 16'h24EC);
		foreach (DIR_KEYS[k]) begin
			load_key(DIR_KEYS[k]);
			foreach (DIR_BLOCKS[b]) begin
				send_word(KIND_ENCRYPT, DIR_BLOCKS[b]);
				send_word(KIND_DECRYPT, DIR_BLOCKS[b]);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: key = 16'hFFFF;
				1: key = 16'h0000;
				default: key = blk_t'($urandom_range(16'hFFFF));
			endcase
			case (ph % 4)
				0: idle_pct = 25;
				1: idle_pct = 0;
				2: idle_pct = 8;
				default: idle_pct = 50;
			endcase
			load_key(key);
			calm = (ph >= RAND_PHASES - 2);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (ph == 3 && n == PHASE_WORDS / 2)
					drain();
				if ($urandom_range(9) == 0)
					blk = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				else
					blk = blk_t'($urandom_range(16'hFFFF));
				send_word(logic'($urandom_range(1)), blk);
			end
		end

		drain();
		repeat (4) @(posedge clk);
		$display("tb_top: %0d words in both directions under %0d keys, idling on both ports",
			words_sent, keys_loaded);
		$display("tb_top: %0d results compared, %0d mismatches", checked, mismatches);
		if (mismatches == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
